>>> sv/dbe_pkg.sv
// Shared constants and control types of the display brightness effect engine.
// Used by dbe_ctrl, dbe_datapath and the core top level; depends on nothing.
package dbe_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);

   // action codes of an input item
   localparam logic [1:0] ACT_START  = 2'd0;
   localparam logic [1:0] ACT_SAMPLE = 2'd1;
   localparam logic [1:0] ACT_STOP   = 2'd2;
   localparam logic [1:0] ACT_LOAD   = 2'd3;

   // effect modes
   localparam logic [2:0] MODE_FADE_IN  = 3'd0;
   localparam logic [2:0] MODE_FADE_OUT = 3'd1;
   localparam logic [2:0] MODE_FOG      = 3'd2;
   localparam logic [2:0] MODE_SHUFFLE  = 3'd3;
   localparam logic [2:0] MODE_BLINK    = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_MODE          = 3'd0;
   localparam logic [2:0] CSR_PERIOD        = 3'd1;
   localparam logic [2:0] CSR_TARGET        = 3'd2;
   localparam logic [2:0] CSR_SHUFFLE_STEPS = 3'd3;
   localparam logic [2:0] CSR_MAX_LEVEL     = 3'd4;
   localparam logic [2:0] CSR_COUNT         = 3'd5;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic div_start;
      logic step_load;
      logic apply;
      logic apply_end;
      logic emit;
   } dbe_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic timed;
      logic div_done;
      logic walk_last;
      logic emit_done;
   } dbe_status_type;

endpackage

>>> sv/dbe_div.sv
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// Standalone unit used by dbe_datapath; no package needed.
module dbe_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic [31:0] quotient,
   output logic        done
);

   logic [31:0] quot_ff;
   logic [15:0] rem_ff;
   logic [15:0] dsr_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [16:0] shifted;
   logic        fits;
   logic [16:0] diff;

   always_comb begin
      shifted = {rem_ff, quot_ff[31]};
      fits    = shifted >= {1'b0, dsr_ff};
      diff    = shifted - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quot_ff <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= fits ? diff[15:0] : shifted[15:0];
            quot_ff <= {quot_ff[30:0], fits};
            cnt_ff  <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

>>> sv/dbe_datapath.sv
// Datapath: configuration registers, element level stores, effect state,
// element walk, step divider and result register. Depends on dbe_pkg and dbe_div.
module dbe_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  dbe_pkg::dbe_cmd_type   cmd,
   output dbe_pkg::dbe_status_type status,
   input  logic [1:0]             req_action,
   input  logic [31:0]            req_now_ms,
   input  logic [3:0]             req_random_index,
   input  logic [3:0]             req_element_index,
   input  logic [7:0]             req_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_element_index_res,
   output logic [7:0]             rsp_level_res,
   output logic                   rsp_last,
   output logic                   rsp_active,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_data
);
   import dbe_pkg::*;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ELEMENTS - 1);

   // configuration
   logic [2:0]  mode_ff;
   logic [15:0] period_ff;
   logic [4:0]  target_ff;
   logic [7:0]  shuf_steps_ff;
   logic [7:0]  max_ff;
   logic [4:0]  count_ff;

   // effect state
   logic [7:0]  levels_ff [MAX_ELEMENTS];
   logic [7:0]  saved_ff  [MAX_ELEMENTS];
   logic [31:0] start_ff;
   logic [31:0] step_ff;
   logic        running_ff;
   logic        rising_ff;
   logic        blink_ff;
   logic [3:0]  pick_ff;

   // item being worked on
   logic [1:0]  act_ff;
   logic [31:0] now_ff;
   logic [3:0]  rnd_ff;
   logic [3:0]  eidx_ff;
   logic [7:0]  lvl_ff;
   logic        adv_ff;
   logic        fin_ff;
   logic        all_ok_ff;
   logic [IDX_W-1:0] idx_ff;

   // result register
   logic        rsp_valid_ff;
   logic [3:0]  rsp_idx_ff;
   logic [7:0]  rsp_lvl_ff;
   logic        rsp_last_ff;
   logic        rsp_active_ff;

   logic [31:0] quot;
   logic        div_done;

   logic [4:0]  n;
   logic [3:0]  n_m1;
   logic [3:0]  newpick;
   logic        shuf_end;
   logic [7:0]  lv;
   logic [7:0]  sv;
   logic        in_use;
   logic        is_tgt;
   logic [7:0]  sat_lvl;
   logic [7:0]  ap_lv;
   logic [7:0]  ap_sv;
   logic        ap_fin;
   logic        ap_ok;
   logic        end_fin;
   logic [7:0]  em_lv;
   logic        em_load;
   logic        em_last;
   logic        rsp_valid_in;

   function automatic logic [3:0] mod_count(input logic [3:0] value, input logic [4:0] cnt);
      logic [4:0] r;
      r = '0;
      for (int k = 3; k >= 0; k--) begin
         r = {r[3:0], value[k]};
         if (r >= cnt) r = r - cnt;
      end
      return r[3:0];
   endfunction

   dbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (now_ff - start_ff),
      .divisor  (period_ff),
      .quotient (quot),
      .done     (div_done)
   );

   always_comb begin
      if (count_ff == 5'd0)                    n = 5'd1;
      else if (count_ff > 5'(MAX_ELEMENTS))    n = 5'(MAX_ELEMENTS);
      else                                     n = count_ff;
      n_m1     = 4'(n - 5'd1);
      newpick  = mod_count(rnd_ff, n);
      shuf_end = step_ff >= {24'd0, shuf_steps_ff};
      lv       = levels_ff[idx_ff];
      sv       = saved_ff[idx_ff];
      in_use   = 5'(idx_ff) < n;
      is_tgt   = 5'(idx_ff) == target_ff;
      sat_lvl  = (lvl_ff > max_ff) ? max_ff : lvl_ff;
   end

   // per-element update of the walk
   always_comb begin
      ap_lv  = lv;
      ap_sv  = sv;
      ap_fin = 1'b0;
      ap_ok  = 1'b1;
      case (act_ff)
         ACT_START: begin
            case (mode_ff)
               MODE_FADE_IN: if (in_use && is_tgt) ap_lv = '0;
               MODE_SHUFFLE: if (in_use) ap_lv = '0;
               MODE_BLINK:   if (in_use) ap_sv = lv;
               default: ;
            endcase
         end
         ACT_LOAD: begin
            if (5'(idx_ff) == 5'(eidx_ff)) ap_lv = sat_lvl;
         end
         ACT_SAMPLE: begin
            if (adv_ff) begin
               case (mode_ff)
                  MODE_FADE_IN: begin
                     if (in_use && is_tgt) begin
                        if (lv < max_ff) ap_lv = lv + 8'd1;
                        else             ap_fin = 1'b1;
                     end
                  end
                  MODE_FADE_OUT: begin
                     if (in_use && is_tgt) begin
                        if (lv != 8'd0) ap_lv = lv - 8'd1;
                        else            ap_fin = 1'b1;
                     end
                  end
                  MODE_FOG: begin
                     if (rising_ff) begin
                        if (in_use) begin
                           if (lv < max_ff) ap_lv = lv + 8'd1;
                           ap_ok = ap_lv >= max_ff;
                        end
                     end else if (in_use && !is_tgt) begin
                        if (lv != 8'd0) ap_lv = lv - 8'd1;
                        ap_ok = ap_lv == 8'd0;
                     end
                  end
                  MODE_SHUFFLE: begin
                     // clear the old pick first, so a repeated pick ends lit
                     if (5'(idx_ff) == 5'(pick_ff)) ap_lv = '0;
                     if (!shuf_end && 5'(idx_ff) == 5'(newpick)) ap_lv = max_ff;
                  end
                  MODE_BLINK: begin
                     if (in_use) ap_lv = blink_ff ? 8'd0 : sv;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // end of walk: does the effect finish
   always_comb begin
      end_fin = fin_ff || (act_ff == ACT_STOP);
      if (act_ff == ACT_SAMPLE && adv_ff) begin
         if (mode_ff == MODE_FOG && !rising_ff && all_ok_ff) end_fin = 1'b1;
         if (mode_ff == MODE_SHUFFLE && shuf_end)              end_fin = 1'b1;
      end
   end

   // emission: apply the end pattern on the way out when finishing
   always_comb begin
      em_lv = lv;
      if (fin_ff) begin
         case (mode_ff) inside
            MODE_FADE_IN:  if (is_tgt) em_lv = max_ff;
            MODE_FADE_OUT: if (is_tgt) em_lv = '0;
            MODE_FOG,
            MODE_SHUFFLE:  em_lv = is_tgt ? max_ff : 8'd0;
            MODE_BLINK:    em_lv = sv;
            default: ;
         endcase
      end
      em_load = cmd.emit && (!rsp_valid_ff || !rsp_stall);
      em_last = 4'(idx_ff) == n_m1;
      if (em_load)                         rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else                                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_FADE_IN;
         period_ff     <= 16'd100;
         target_ff     <= 5'd0;
         shuf_steps_ff <= 8'd10;
         max_ff        <= 8'd10;
         count_ff      <= 5'd10;
         for (int i = 0; i < MAX_ELEMENTS; i++) begin
            levels_ff[i] <= '0;
            saved_ff[i]  <= '0;
         end
         start_ff     <= '0;
         step_ff      <= '0;
         running_ff   <= 1'b0;
         rising_ff    <= 1'b1;
         blink_ff     <= 1'b1;
         pick_ff      <= '0;
         act_ff       <= ACT_START;
         adv_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         all_ok_ff    <= 1'b1;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MODE:          mode_ff       <= csr_data[2:0];
               CSR_PERIOD:        period_ff     <= csr_data;
               CSR_TARGET:        target_ff     <= csr_data[4:0];
               CSR_SHUFFLE_STEPS: shuf_steps_ff <= csr_data[7:0];
               CSR_MAX_LEVEL:     max_ff        <= csr_data[7:0];
               CSR_COUNT:         count_ff      <= csr_data[4:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            act_ff    <= req_action;
            now_ff    <= req_now_ms;
            rnd_ff    <= req_random_index;
            eidx_ff   <= req_element_index;
            lvl_ff    <= req_level;
            adv_ff    <= 1'b0;
            fin_ff    <= 1'b0;
            all_ok_ff <= 1'b1;
            idx_ff    <= '0;
         end
         if (cmd.step_load && quot != step_ff) begin
            step_ff <= quot;
            adv_ff  <= 1'b1;
         end
         if (cmd.apply) begin
            levels_ff[idx_ff] <= ap_lv;
            saved_ff[idx_ff]  <= ap_sv;
            fin_ff            <= fin_ff | ap_fin;
            all_ok_ff         <= all_ok_ff & ap_ok;
            idx_ff            <= (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
         end
         if (cmd.apply_end) begin
            fin_ff <= end_fin;
            case (act_ff)
               ACT_START: begin
                  start_ff   <= now_ff;
                  step_ff    <= '0;
                  running_ff <= 1'b1;
                  case (mode_ff)
                     MODE_FOG:     rising_ff <= 1'b1;
                     MODE_SHUFFLE: pick_ff   <= newpick;
                     MODE_BLINK:   blink_ff  <= 1'b1;
                     default: ;
                  endcase
               end
               ACT_SAMPLE: begin
                  if (adv_ff) begin
                     case (mode_ff)
                        MODE_FOG:     if (rising_ff && all_ok_ff) rising_ff <= 1'b0;
                        MODE_SHUFFLE: if (!shuf_end) pick_ff <= newpick;
                        MODE_BLINK:   blink_ff <= !blink_ff;
                        default: ;
                     endcase
                  end
               end
               default: ;
            endcase
            if (end_fin) running_ff <= 1'b0;
         end
         if (em_load) begin
            levels_ff[idx_ff] <= em_lv;
            idx_ff            <= em_last ? '0 : idx_ff + 1'b1;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (em_load) begin
         rsp_idx_ff    <= 4'(idx_ff);
         rsp_lvl_ff    <= em_lv;
         rsp_last_ff   <= em_last;
         rsp_active_ff <= running_ff;
      end
   end

   assign status.timed     = running_ff && (period_ff != 16'd0);
   assign status.div_done  = div_done;
   assign status.walk_last = idx_ff == IDX_LAST;
   assign status.emit_done = em_load && em_last;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_element_index_res = rsp_idx_ff;
   assign rsp_level_res         = rsp_lvl_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_active            = rsp_active_ff;

endmodule

>>> sv/dbe_ctrl.sv
// Controller state machine: item acceptance, step division, element walk and
// result emission sequencing. Depends on dbe_pkg.
module dbe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_action,
   input  dbe_pkg::dbe_status_type status,
   output dbe_pkg::dbe_cmd_type    cmd
);
   import dbe_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_APPLY,
      S_APPLY_END,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd           = '0;
      cmd.capture   = accept;
      cmd.div_start = state_ff == S_DIV_GO;
      cmd.step_load = (state_ff == S_DIV_WAIT) && status.div_done;
      cmd.apply     = state_ff == S_APPLY;
      cmd.apply_end = state_ff == S_APPLY_END;
      cmd.emit      = state_ff == S_EMIT;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // only a timed sample needs the step quotient
               if (req_action == ACT_SAMPLE && status.timed) state_in = S_DIV_GO;
               else                                         state_in = S_APPLY;
            end
         end
         S_DIV_GO:    state_in = S_DIV_WAIT;
         S_DIV_WAIT:  if (status.div_done) state_in = S_APPLY;
         S_APPLY:     if (status.walk_last) state_in = S_APPLY_END;
         S_APPLY_END: state_in = S_EMIT;
         S_EMIT:      if (status.emit_done) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/display_brightness_effect_engine_core.sv
// Top level of the display brightness effect engine: controller plus datapath.
// Depends on dbe_pkg, dbe_ctrl, dbe_datapath (and dbe_div below it).
//
// Usage:
//   Request channel (req_*): one item is an action with its time sample, random
//   pick, element index and level. It is taken when req_valid is high and
//   req_stall is low; req_stall stays high while an item is in work.
//   Result channel (rsp_*): each item yields one result per element in use,
//   indexes 0 to count-1 (count held to 1..16) in order, rsp_last marks the last.
//   Configuration port (csr_*): always ready; write only while the block idles.
// Sequence:
//   Every item walks all 16 level entries, settles and wraps up, then emits
//   one result per cycle whenever rsp_stall does not hold the output register.
//   A time sample while running with a nonzero period adds the serial step
//   divider, one quotient bit per cycle. The next item is taken as soon as
//   the last result sits in the output register; a stall on rsp_stall holds
//   that register and pauses emission.
// Reset: synchronous; levels and saved levels clear to zero, configuration
//   takes its defaults, the effect is inactive and no result is pending.
module display_brightness_effect_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_now_ms,
   input  logic [3:0]  req_random_index,
   input  logic [3:0]  req_element_index,
   input  logic [7:0]  req_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_element_index_res,
   output logic [7:0]  rsp_level_res,
   output logic        rsp_last,
   output logic        rsp_active,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import dbe_pkg::*;

   dbe_cmd_type    cmd;
   dbe_status_type status;

   assign csr_ready = 1'b1;

   dbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   dbe_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_action            (req_action),
      .req_now_ms            (req_now_ms),
      .req_random_index      (req_random_index),
      .req_element_index     (req_element_index),
      .req_level             (req_level),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_element_index_res (rsp_element_index_res),
      .rsp_level_res         (rsp_level_res),
      .rsp_last              (rsp_last),
      .rsp_active            (rsp_active),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

endmodule

>>> verif/display_brightness_effect_engine_core_tb.sv
// Self-checking bench for display_brightness_effect_engine_core: directed and random effect runs
// with random idling, checked per result against an in-bench level predictor.
// Depends on dbe_pkg and the core RTL below it.
module display_brightness_effect_engine_core_tb;
   import dbe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 190;
   localparam int END_SETTLE     = 100;

   localparam logic [2:0] CSR_SPARE_LO  = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI  = 3'd7;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [3:0] index;
      logic [7:0] level;
      logic       last;
      logic       active;
   } level_report_type;

   class level_scoreboard;
      logic [2:0]       mode;
      logic [15:0]      period_ms;
      logic [4:0]       target;
      logic [7:0]       shuffle_steps;
      logic [7:0]       max_level;
      logic [4:0]       count_cfg;
      logic [7:0]       levels [MAX_ELEMENTS];
      logic [7:0]       saved_levels [MAX_ELEMENTS];
      logic [31:0]      start_time;
      logic [31:0]      step_count;
      logic             running;
      logic             rising_phase;
      logic             blink_lit;
      logic [3:0]       shuffle_pick;
      level_report_type expected_levels[$];
      int               mismatches;
      int               results_checked;
      int               effect_steps;
      int               action_count [4];

      function new();
         mode = MODE_FADE_IN;
         period_ms = 16'd100;
         target = 5'd0;
         shuffle_steps = 8'd10;
         max_level = 8'd10;
         count_cfg = 5'd10;
         foreach (levels[i]) begin
            levels[i] = 8'd0;
            saved_levels[i] = 8'd0;
         end
         start_time = 32'd0;
         step_count = 32'd0;
         running = 1'b0;
         rising_phase = 1'b1;
         blink_lit = 1'b1;
         shuffle_pick = 4'd0;
         mismatches = 0;
         results_checked = 0;
         effect_steps = 0;
         foreach (action_count[i]) action_count[i] = 0;
      endfunction

      function int unsigned elements_in_use();
         if (count_cfg == 0) return 1;
         if (count_cfg > MAX_ELEMENTS) return MAX_ELEMENTS;
         return count_cfg;
      endfunction

      function void write_reg(logic [2:0] index, logic [15:0] data);
         case (index)
            CSR_MODE:          mode = data[2:0];
            CSR_PERIOD:        period_ms = data;
            CSR_TARGET:        target = data[4:0];
            CSR_SHUFFLE_STEPS: shuffle_steps = data[7:0];
            CSR_MAX_LEVEL:     max_level = data[7:0];
            CSR_COUNT:         count_cfg = data[4:0];
            default: ;
         endcase
      endfunction

      function void apply_end_pattern();
         int unsigned n;
         int unsigned i;
         bit          has_target;
         n = elements_in_use();
         has_target = target < n;
         case (mode) inside
            MODE_FADE_IN: begin
               if (has_target) levels[target] = max_level;
            end
            MODE_FADE_OUT: begin
               if (has_target) levels[target] = 8'd0;
            end
            MODE_FOG, MODE_SHUFFLE: begin
               for (i = 0; i < n; i++) levels[i] = (i == target) ? max_level : 8'd0;
            end
            MODE_BLINK: begin
               for (i = 0; i < n; i++) levels[i] = saved_levels[i];
            end
            default: ;
         endcase
         running = 1'b0;
      endfunction

      function void advance_effect(logic [3:0] pick_in);
         int unsigned n;
         int unsigned i;
         int unsigned settled;
         bit          has_target;
         n = elements_in_use();
         settled = 0;
         has_target = target < n;
         case (mode)
            MODE_FADE_IN: begin
               if (has_target) begin
                  if (levels[target] < max_level) levels[target] = levels[target] + 8'd1;
                  else apply_end_pattern();
               end
            end
            MODE_FADE_OUT: begin
               if (has_target) begin
                  if (levels[target] > 0) levels[target] = levels[target] - 8'd1;
                  else apply_end_pattern();
               end
            end
            MODE_FOG: begin
               if (rising_phase) begin
                  for (i = 0; i < n; i++) begin
                     if (levels[i] < max_level) levels[i] = levels[i] + 8'd1;
                     if (levels[i] >= max_level) settled++;
                  end
                  if (settled >= n) rising_phase = 1'b0;
               end else begin
                  // the target keeps its level while the rest fall
                  for (i = 0; i < n; i++) begin
                     if (i != target) begin
                        if (levels[i] > 0) levels[i] = levels[i] - 8'd1;
                        if (levels[i] == 0) settled++;
                     end
                  end
                  if (settled >= (has_target ? n - 1 : n)) apply_end_pattern();
               end
            end
            MODE_SHUFFLE: begin
               levels[shuffle_pick] = 8'd0;
               if (step_count >= shuffle_steps) begin
                  apply_end_pattern();
               end else begin
                  shuffle_pick = 4'(pick_in % n);
                  levels[shuffle_pick] = max_level;
               end
            end
            MODE_BLINK: begin
               for (i = 0; i < n; i++) levels[i] = blink_lit ? 8'd0 : saved_levels[i];
               blink_lit = !blink_lit;
            end
            default: ;
         endcase
      endfunction

      // update the predicted levels for one accepted item and queue its results
      function void note_item(logic [1:0] action, logic [31:0] now, logic [3:0] pick_in,
                              logic [3:0] element, logic [7:0] level);
         int unsigned      n;
         int unsigned      i;
         logic [31:0]      quotient;
         level_report_type r;
         n = elements_in_use();
         action_count[action]++;
         case (action)
            ACT_START: begin
               start_time = now;
               step_count = 32'd0;
               case (mode)
                  MODE_FADE_IN: begin
                     if (target < n) levels[target] = 8'd0;
                  end
                  MODE_FOG: rising_phase = 1'b1;
                  MODE_SHUFFLE: begin
                     shuffle_pick = 4'(pick_in % n);
                     for (i = 0; i < n; i++) levels[i] = 8'd0;
                  end
                  MODE_BLINK: begin
                     blink_lit = 1'b1;
                     for (i = 0; i < n; i++) saved_levels[i] = levels[i];
                  end
                  default: ;
               endcase
               running = 1'b1;
            end
            ACT_SAMPLE: begin
               if (running && period_ms != 0) begin
                  quotient = (now - start_time) / period_ms;
                  if (quotient != step_count) begin
                     step_count = quotient;
                     effect_steps++;
                     advance_effect(pick_in);
                  end
               end
            end
            ACT_STOP: apply_end_pattern();
            default: levels[element] = (level > max_level) ? max_level : level;
         endcase
         for (i = 0; i < n; i++) begin
            r.index = 4'(i);
            r.level = levels[i];
            r.last = (i == n - 1);
            r.active = running;
            expected_levels.push_back(r);
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task check_result(logic [3:0] index, logic [7:0] level, logic last, logic active);
         level_report_type want;
         results_checked++;
         if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("unexpected result, element %0d level %0d", index, level));
            return;
         end
         want = expected_levels.pop_front();
         if (index !== want.index)
            report_mismatch($sformatf("element index %0d, expected %0d", index, want.index));
         if (level !== want.level)
            report_mismatch($sformatf("element %0d level %0d, expected %0d",
                                      want.index, level, want.level));
         if (last !== want.last)
            report_mismatch($sformatf("element %0d last %0b, expected %0b",
                                      want.index, last, want.last));
         if (active !== want.active)
            report_mismatch($sformatf("element %0d active %0b, expected %0b",
                                      want.index, active, want.active));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_SAMPLE;
   logic [31:0] req_now_ms = 32'd0;
   logic [3:0]  req_random_index = 4'd0;
   logic [3:0]  req_element_index = 4'd0;
   logic [7:0]  req_level = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_element_index_res;
   logic [7:0]  rsp_level_res;
   logic        rsp_last;
   logic        rsp_active;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_MODE;
   logic [15:0] csr_data = 16'd0;

   level_scoreboard board;
   int              items_sent = 0;
   int              settings_used = 0;
   int              idle_cycles = 0;
   bit              quiet = 1'b0;

   display_brightness_effect_engine_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_now_ms            (req_now_ms),
      .req_random_index      (req_random_index),
      .req_element_index     (req_element_index),
      .req_level             (req_level),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_element_index_res (rsp_element_index_res),
      .rsp_level_res         (rsp_level_res),
      .rsp_last              (rsp_last),
      .rsp_active            (rsp_active),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver: stall at random except during the quiet stretch
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 19);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_element_index_res, rsp_level_res, rsp_last, rsp_active);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", idle_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_item(logic [1:0] action, logic [31:0] now, logic [3:0] pick_in,
                            logic [3:0] element, logic [7:0] level);
      if (!quiet) begin
         while ($urandom_range(99) < 19) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_now_ms <= now;
      req_random_index <= pick_in;
      req_element_index <= element;
      req_level <= level;
      do @(posedge clock); while (req_stall);
      board.note_item(action, now, pick_in, element, level);
      items_sent++;
      quiet = (items_sent >= 90 && items_sent < 150);
   endtask

   // hold off until every queued result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.expected_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(index, data);
   endtask

   task automatic set_effect(logic [15:0] mode, logic [15:0] period, logic [15:0] target,
                             logic [15:0] steps, logic [15:0] max_level, logic [15:0] count);
      write_reg(CSR_MODE, mode);
      write_reg(CSR_PERIOD, period);
      write_reg(CSR_TARGET, target);
      write_reg(CSR_SHUFFLE_STEPS, steps);
      write_reg(CSR_MAX_LEVEL, max_level);
      write_reg(CSR_COUNT, count);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random_setting();
      logic [15:0] mode;
      logic [15:0] period;
      logic [15:0] count;
      logic [15:0] target;
      logic [15:0] steps;
      logic [15:0] max_level;
      logic [31:0] t;
      int unsigned n;
      int unsigned span;
      if ($urandom_range(9) == 0) mode = 16'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else mode = 16'($urandom_range(MODE_FADE_IN, MODE_BLINK));
      case ($urandom_range(9))
         0: period = 16'd0;
         1: period = 16'($urandom);
         default: period = 16'($urandom_range(1, 8));
      endcase
      case ($urandom_range(9))
         0: count = 16'd0;
         1: count = 16'($urandom_range(MAX_ELEMENTS + 1, 31));
         2: count = 16'(MAX_ELEMENTS);
         default: count = 16'($urandom_range(1, 12));
      endcase
      n = (count == 0) ? 1 : (count > MAX_ELEMENTS) ? MAX_ELEMENTS : count;
      if ($urandom_range(7) == 0) target = 16'($urandom_range(n, 31));
      else target = 16'($urandom_range(0, n - 1));
      steps = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 255))
                                        : 16'($urandom_range(0, 12));
      case ($urandom_range(11))
         0: max_level = 16'd0;
         1: max_level = 16'd255;
         2: max_level = 16'($urandom_range(0, 255));
         default: max_level = 16'($urandom_range(1, 6));
      endcase
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, 16'($urandom));
      set_effect(mode, period, target, steps, max_level, count);

      repeat ($urandom_range(0, 3))
         push_item(ACT_LOAD, $urandom, 4'($urandom), 4'($urandom), 8'($urandom));
      t = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
      push_item(ACT_START, t, 4'($urandom), 4'($urandom), 8'($urandom));
      span = (period == 0) ? 20 : 2 * period;
      repeat ($urandom_range(3, 20)) begin
         case ($urandom_range(19))
            0: push_item(2'($urandom), $urandom, 4'($urandom), 4'($urandom), 8'($urandom));
            1: push_item(ACT_LOAD, t, 4'($urandom), 4'($urandom), 8'($urandom));
            2: drain_results();
            default: begin
               t = t + $urandom_range(0, span);
               push_item(ACT_SAMPLE, t, 4'($urandom), 4'($urandom), 8'($urandom));
            end
         endcase
      end
      if ($urandom_range(3) != 0)
         push_item(ACT_STOP, t, 4'($urandom), 4'($urandom), 8'($urandom));
      drain_results();
   endtask

   initial begin
      int directed_items;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: fade in on element 0 of ten, 100 ms per step
      push_item(ACT_SAMPLE, 32'd50, 4'($urandom), 4'($urandom), 8'($urandom));
      push_item(ACT_LOAD, $urandom, 4'($urandom), 4'd15, 8'hFF);
      push_item(ACT_START, 32'hFFFF_FFC0, 4'($urandom), 4'($urandom), 8'($urandom));
      push_item(ACT_SAMPLE, 32'h0000_0024, 4'($urandom), 4'($urandom), 8'($urandom));
      push_item(ACT_SAMPLE, 32'h0000_0088, 4'($urandom), 4'($urandom), 8'($urandom));
      push_item(ACT_STOP, 32'd0, 4'($urandom), 4'($urandom), 8'($urandom));
      drain_results();

      // fog over three elements, up to two and back down around the target
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'h0000);
      set_effect(16'(MODE_FOG), 16'd1, 16'd1, 16'd0, 16'd2, 16'd3);
      push_item(ACT_START, 32'd0, 4'($urandom), 4'($urandom), 8'($urandom));
      for (int s = 1; s <= 5; s++)
         push_item(ACT_SAMPLE, s, 4'($urandom), 4'($urandom), 8'($urandom));
      drain_results();

      // shuffle on all sixteen elements with no target, ends on its own
      set_effect(16'(MODE_SHUFFLE), 16'hFFFF, 16'd31, 16'd2, 16'd255, 16'd16);
      push_item(ACT_START, 32'd0, 4'd15, 4'($urandom), 8'($urandom));
      push_item(ACT_SAMPLE, 32'd65535, 4'd0, 4'($urandom), 8'($urandom));
      push_item(ACT_SAMPLE, 32'd131070, 4'd7, 4'($urandom), 8'($urandom));
      push_item(ACT_SAMPLE, 32'd196605, 4'($urandom), 4'($urandom), 8'($urandom));
      drain_results();

      // blink with a zero count and a zero period, then give it a period
      set_effect(16'(MODE_BLINK), 16'd0, 16'd0, 16'd255, 16'd1, 16'd0);
      push_item(ACT_LOAD, $urandom, 4'($urandom), 4'd0, 8'd1);
      push_item(ACT_START, 32'd0, 4'($urandom), 4'($urandom), 8'($urandom));
      push_item(ACT_SAMPLE, 32'd7, 4'($urandom), 4'($urandom), 8'($urandom));
      drain_results();
      write_reg(CSR_PERIOD, 16'd2);
      csr_valid <= 1'b0;
      push_item(ACT_SAMPLE, 32'd2, 4'($urandom), 4'($urandom), 8'($urandom));
      push_item(ACT_SAMPLE, 32'd4, 4'($urandom), 4'($urandom), 8'($urandom));
      push_item(ACT_STOP, 32'd4, 4'($urandom), 4'($urandom), 8'($urandom));
      drain_results();

      // fade out of the last element with an oversized count
      set_effect(16'(MODE_FADE_OUT), 16'd1, 16'd15, 16'd0, 16'd255, 16'd31);
      push_item(ACT_LOAD, $urandom, 4'($urandom), 4'd15, 8'd2);
      push_item(ACT_START, 32'd100, 4'($urandom), 4'($urandom), 8'($urandom));
      for (int s = 101; s <= 103; s++)
         push_item(ACT_SAMPLE, s, 4'($urandom), 4'($urandom), 8'($urandom));
      drain_results();

      directed_items = items_sent;
      while (items_sent < directed_items + RANDOM_ITEMS) run_random_setting();

      req_valid <= 1'b0;
      while (board.expected_levels.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      $display("Covered %0d starts, %0d time samples (%0d effect steps), %0d stops, %0d loads",
               board.action_count[ACT_START], board.action_count[ACT_SAMPLE],
               board.effect_steps, board.action_count[ACT_STOP], board.action_count[ACT_LOAD]);
      $display("over %0d register settings; %0d results compared, %0d mismatches",
               settings_used, board.results_checked, board.mismatches);
      if (board.mismatches == 0 && board.expected_levels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
